/* hw/rtl/fbpa_pkg.sv */
// Shared types, constants and helper functions for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int POOL_SLOTS = 256;
    localparam int ALIGNMENT  = 16;
    localparam int NODE_BYTES = 8;

    localparam int MAX_OBJECT  = 4096;
    localparam int RESET_OBJ   = 64;
    localparam int RESET_COUNT = 256;
    localparam int RESET_BASE  = 4096;

    localparam int OBJ_W    = 13;
    localparam int COUNT_W  = 9;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 9;

    localparam int IDX_W   = $clog2(POOL_SLOTS);
    localparam int DEPTH_W = $clog2(POOL_SLOTS + 1);

    localparam int SIZE_MAX  = (MAX_OBJECT > NODE_BYTES) ? MAX_OBJECT : NODE_BYTES;
    localparam int CHUNK_MAX = ((SIZE_MAX + ALIGNMENT - 1) / ALIGNMENT) * ALIGNMENT;
    localparam int CHUNK_W   = $clog2(CHUNK_MAX + 1);
    localparam int PROD_W    = CHUNK_W + DEPTH_W;
    localparam int CNT_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SLOTS_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE       = 2'd2;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_EXHAUSTED  = 3'd1,
        ST_NULL       = 3'd2,
        ST_RANGE      = 3'd3,
        ST_MISALIGNED = 3'd4,
        ST_FULL       = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_RANGE,
        S_FREE_DIV,
        S_FREE_PUSH
    } t_state;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } t_stack_req;

    function automatic logic [CHUNK_W-1:0] f_chunk_bytes(input logic [OBJ_W-1:0] obj);
        logic [31:0] sz;
        sz = 32'(obj);
        if (sz > 32'(MAX_OBJECT)) begin
            sz = 32'(MAX_OBJECT);
        end
        if (sz < 32'(NODE_BYTES)) begin
            sz = 32'(NODE_BYTES);
        end
        sz = ((sz + 32'(ALIGNMENT - 1)) / ALIGNMENT) * ALIGNMENT;
        return CHUNK_W'(sz);
    endfunction

    function automatic logic [DEPTH_W-1:0] f_clamp_slots(input logic [COUNT_W-1:0] cnt);
        if (32'(cnt) > 32'(POOL_SLOTS)) begin
            return DEPTH_W'(POOL_SLOTS);
        end
        return DEPTH_W'(cnt);
    endfunction

endpackage

/* hw/rtl/fbpa_stack.sv */
// Free slot stack memory with per-entry valid bits; an unwritten entry reads as its own index.
`timescale 1ns / 1ps

module fbpa_stack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fbpa_pkg::t_stack_req        i_req,
    output logic [fbpa_pkg::IDX_W-1:0]  o_rd_slot
);
    import fbpa_pkg::*;

    logic [IDX_W-1:0]      r_mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_valid;
    logic [IDX_W-1:0]      r_rd_data;
    logic [IDX_W-1:0]      r_rd_addr;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
            r_rd_addr  <= i_req.rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_slot = r_rd_valid ? r_rd_data : r_rd_addr;

endmodule

/* hw/rtl/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator: sequencer, shared datapath and registers.
//
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------------
// request   | start, busy        | i_opcode, i_chunk_address
// result    | o_strobe           | o_granted_address, o_status, o_free_chunks
// config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A transaction is taken when start is high and busy is low; its result appears on
// o_strobe after the last state of its path: add for a granted allocate, push for a
// free that reaches the push step, and decode for exhausted or null requests.
// The free path finds the slot index by 8 restoring division steps through the shared subtractor.
// A new transaction can be taken in the cycle the previous result is shown.
// The result receiver cannot stall, so each result is shown for a single cycle.
// Reset and count writes refill the free stack at once through valid bits.
`timescale 1ns / 1ps

module fixed_block_pool_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [fbpa_pkg::ADDR_W-1:0]     i_chunk_address,
    output logic                            o_strobe,
    output logic [fbpa_pkg::ADDR_W-1:0]     o_granted_address,
    output logic [fbpa_pkg::STATUS_W-1:0]   o_status,
    output logic [fbpa_pkg::FREE_W-1:0]     o_free_chunks,
    input  logic                            i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]     i_cfg_data
);
    import fbpa_pkg::*;

    t_state             r_state, n_state;
    t_opcode            r_opcode, n_opcode;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [DEPTH_W-1:0] r_used, n_used;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [PROD_W-1:0]  r_rem, n_rem;
    logic [PROD_W-1:0]  r_div, n_div;
    logic [IDX_W-1:0]   r_quot, n_quot;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_strobe, n_strobe;
    logic [ADDR_W-1:0]  r_granted, n_granted;
    t_status            r_status, n_status;
    logic [FREE_W-1:0]  r_free, n_free;

    t_stack_req         stack_req;
    logic [IDX_W-1:0]   rd_slot;

    logic               accept;
    logic               stack_empty;
    logic [DEPTH_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic [ADDR_W:0]    pool_limit;
    logic [ADDR_W:0]    sub_a, sub_b;
    logic [ADDR_W+1:0]  diff;
    logic               borrow;
    logic               out_of_range;

    fbpa_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (stack_req),
        .o_rd_slot (rd_slot)
    );

    assign accept      = start && (r_state == S_IDLE);
    assign stack_empty = (r_depth == '0) || (32'(r_depth) > 32'(POOL_SLOTS));

    assign mul_b      = (r_opcode == OP_ALLOC) ? DEPTH_W'(rd_slot) : r_used;
    assign mul_prod   = PROD_W'(r_chunk) * PROD_W'(mul_b);
    assign pool_limit = {1'b0, r_base} + (ADDR_W + 1)'(r_prod);

    assign sub_a  = (r_state == S_FREE_DIV) ? (ADDR_W + 1)'(r_rem) : {1'b0, r_addr};
    assign sub_b  = (r_state == S_FREE_DIV) ? (ADDR_W + 1)'(r_div) : {1'b0, r_base};
    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow = diff[ADDR_W+1];

    assign out_of_range = borrow || ({1'b0, r_addr} >= pool_limit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_opcode == OP_ALLOC) begin
                    n_state = stack_empty ? S_IDLE : S_ALLOC_MUL;
                end else begin
                    n_state = (r_addr == '0) ? S_IDLE : S_FREE_RANGE;
                end
            end
            S_ALLOC_MUL:  n_state = S_ALLOC_ADD;
            S_ALLOC_ADD:  n_state = S_IDLE;
            S_FREE_RANGE: n_state = out_of_range ? S_IDLE : S_FREE_DIV;
            S_FREE_DIV: begin
                if (r_count == '0) begin
                    n_state = S_FREE_PUSH;
                end
            end
            S_FREE_PUSH:  n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_opcode  = r_opcode;
        n_addr    = r_addr;
        n_chunk   = r_chunk;
        n_base    = r_base;
        n_used    = r_used;
        n_depth   = r_depth;
        n_prod    = r_prod;
        n_rem     = r_rem;
        n_div     = r_div;
        n_quot    = r_quot;
        n_count   = r_count;
        n_strobe  = 1'b0;
        n_granted = r_granted;
        n_status  = r_status;
        n_free    = r_free;
        stack_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_opcode = t_opcode'(i_opcode);
                    n_addr   = i_chunk_address;
                end
            end
            S_DECODE: begin
                if (r_opcode == OP_ALLOC) begin
                    if (stack_empty) begin
                        n_strobe  = 1'b1;
                        n_granted = '0;
                        n_status  = ST_EXHAUSTED;
                        n_free    = FREE_W'(r_depth);
                    end else begin
                        stack_req.rd_en   = 1'b1;
                        stack_req.rd_addr = IDX_W'(r_depth - 1'b1);
                        n_depth           = r_depth - 1'b1;
                    end
                end else if (r_addr == '0) begin
                    n_strobe  = 1'b1;
                    n_granted = '0;
                    n_status  = ST_NULL;
                    n_free    = FREE_W'(r_depth);
                end else begin
                    n_prod = mul_prod;
                end
            end
            S_ALLOC_MUL: begin
                n_prod = mul_prod;
            end
            S_ALLOC_ADD: begin
                n_strobe  = 1'b1;
                n_granted = r_base + ADDR_W'(r_prod);
                n_status  = ST_OK;
                n_free    = FREE_W'(r_depth);
            end
            S_FREE_RANGE: begin
                if (out_of_range) begin
                    n_strobe  = 1'b1;
                    n_granted = '0;
                    n_status  = ST_RANGE;
                    n_free    = FREE_W'(r_depth);
                end else begin
                    n_rem   = PROD_W'(diff);
                    n_div   = PROD_W'(r_chunk) << (IDX_W - 1);
                    n_count = CNT_W'(IDX_W - 1);
                    n_quot  = '0;
                end
            end
            S_FREE_DIV: begin
                if (!borrow) begin
                    n_rem = PROD_W'(diff);
                end
                n_quot  = IDX_W'({r_quot, !borrow});
                n_div   = r_div >> 1;
                n_count = r_count - 1'b1;
            end
            S_FREE_PUSH: begin
                n_strobe  = 1'b1;
                n_granted = '0;
                n_free    = FREE_W'(r_depth);
                if (r_rem != '0) begin
                    n_status = ST_MISALIGNED;
                end else if (r_depth >= r_used) begin
                    n_status = ST_FULL;
                end else begin
                    stack_req.wr_en   = 1'b1;
                    stack_req.wr_addr = r_depth[IDX_W-1:0];
                    stack_req.wr_data = r_quot;
                    n_depth           = r_depth + 1'b1;
                    n_status          = ST_OK;
                    n_free            = FREE_W'(r_depth + 1'b1);
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OBJECT_BYTES: begin
                    n_chunk = f_chunk_bytes(i_cfg_data[OBJ_W-1:0]);
                end
                CFG_POOL_SLOTS_USED: begin
                    n_used          = f_clamp_slots(i_cfg_data[COUNT_W-1:0]);
                    n_depth         = f_clamp_slots(i_cfg_data[COUNT_W-1:0]);
                    stack_req.clear = 1'b1;
                end
                CFG_POOL_BASE: begin
                    n_base = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_chunk  <= f_chunk_bytes(OBJ_W'(RESET_OBJ));
            r_base   <= ADDR_W'(RESET_BASE);
            r_used   <= f_clamp_slots(COUNT_W'(RESET_COUNT));
            r_depth  <= f_clamp_slots(COUNT_W'(RESET_COUNT));
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_chunk  <= n_chunk;
            r_base   <= n_base;
            r_used   <= n_used;
            r_depth  <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode  <= n_opcode;
        r_addr    <= n_addr;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_quot    <= n_quot;
        r_count   <= n_count;
        r_granted <= n_granted;
        r_status  <= n_status;
        r_free    <= n_free;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_strobe;
    assign o_granted_address = r_granted;
    assign o_status          = r_status;
    assign o_free_chunks     = r_free;

endmodule

/* hw/rtl/fbpa_checker.sv */
// Port-level assertions for the fixed block pool allocator, bound to the top level.
`timescale 1ns / 1ps

module fbpa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_strobe,
    input logic [fbpa_pkg::ADDR_W-1:0]     o_granted_address,
    input logic [fbpa_pkg::STATUS_W-1:0]   o_status,
    input logic [fbpa_pkg::FREE_W-1:0]     o_free_chunks
);
    import fbpa_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("Result shown while a transaction is still in progress.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("Two results in consecutive cycles.");

    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_OK) |-> (o_granted_address == '0))
        else $error("Address granted with a failing status.");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_free_chunks) <= 32'(POOL_SLOTS)))
        else $error("Free chunk count exceeds the pool size.");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

/* dv/fbpa_grant_monitor.sv */
// Watches the allocator channels, predicts each result and compares it with what the block returns.
`timescale 1ns / 1ps

module fbpa_grant_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           opcode,
    input  logic [fbpa_pkg::ADDR_W-1:0]    chunk_address,
    input  logic                           strobe,
    input  logic [fbpa_pkg::ADDR_W-1:0]    granted_address,
    input  logic [fbpa_pkg::STATUS_W-1:0]  status,
    input  logic [fbpa_pkg::FREE_W-1:0]    free_chunks,
    input  logic                           cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
    output int                             fail_count,
    output int                             results_due
);
    import fbpa_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [FREE_W-1:0] free;
    } t_grant;

    t_grant grants_due[$];
    t_grant predicted;

    logic [OBJ_W-1:0]   obj_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [12:0]        chunk_size;
    logic [IDX_W-1:0]   free_slots [0:POOL_SLOTS-1];
    int unsigned        stack_top;

    function automatic logic [12:0] rounded_chunk(input logic [OBJ_W-1:0] obj);
        int unsigned sz;
        sz = (obj > MAX_OBJECT) ? MAX_OBJECT : obj;
        if (sz < NODE_BYTES) begin
            sz = NODE_BYTES;
        end
        return 13'(((sz + ALIGNMENT - 1) / ALIGNMENT) * ALIGNMENT);
    endfunction

    function automatic int unsigned pool_chunks();
        return (count_reg > POOL_SLOTS) ? POOL_SLOTS : count_reg;
    endfunction

    task automatic refill_stack();
        for (int k = 0; k < POOL_SLOTS; k++) begin
            free_slots[k] = IDX_W'(k);
        end
        stack_top = pool_chunks();
    endtask

    task automatic serve_request(input logic op, input logic [ADDR_W-1:0] addr,
                                 output t_grant res);
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      off;
        logic [IDX_W-1:0] slot;
        int unsigned      used;
        used = pool_chunks();
        lo = 64'(base_reg);
        hi = lo + 64'(chunk_size) * 64'(used);
        res.addr = '0;
        res.status = ST_OK;
        if (op == OP_ALLOC) begin
            if (stack_top == 0) begin
                res.status = ST_EXHAUSTED;
            end else begin
                stack_top--;
                slot = free_slots[stack_top];
                res.addr = 32'(lo + 64'(slot) * 64'(chunk_size));
            end
        end else if (addr == '0) begin
            res.status = ST_NULL;
        end else if (64'(addr) < lo || 64'(addr) >= hi) begin
            res.status = ST_RANGE;
        end else begin
            off = 64'(addr) - lo;
            if (off % 64'(chunk_size) != 0) begin
                res.status = ST_MISALIGNED;
            end else if (stack_top >= used) begin
                res.status = ST_FULL;
            end else begin
                free_slots[stack_top] = IDX_W'(off / 64'(chunk_size));
                stack_top++;
            end
        end
        res.free = FREE_W'(stack_top);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            obj_reg = OBJ_W'(RESET_OBJ);
            count_reg = COUNT_W'(RESET_COUNT);
            base_reg = ADDR_W'(RESET_BASE);
            chunk_size = rounded_chunk(obj_reg);
            refill_stack();
            grants_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_OBJECT_BYTES: begin
                        obj_reg = cfg_data[OBJ_W-1:0];
                        chunk_size = rounded_chunk(obj_reg);
                    end
                    CFG_POOL_SLOTS_USED: begin
                        count_reg = cfg_data[COUNT_W-1:0];
                        refill_stack();
                    end
                    CFG_POOL_BASE: begin
                        base_reg = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (strobe) begin
                if (grants_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with no transaction outstanding: addr %h status %0d",
                                 $realtime, granted_address, status);
                    end
                end else begin
                    predicted = grants_due.pop_front();
                    if (granted_address !== predicted.addr || status !== predicted.status ||
                        free_chunks !== predicted.free) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: result mismatch: expected addr %h status %0d free %0d, got addr %h status %0d free %0d",
                                     $realtime, predicted.addr, predicted.status, predicted.free,
                                     granted_address, status, free_chunks);
                        end
                    end
                end
            end
            if (start && !busy) begin
                serve_request(opcode, chunk_address, predicted);
                grants_due.push_back(predicted);
            end
        end
        results_due = grants_due.size();
    end

endmodule

/* dv/tb_fixed_block_pool_allocator.sv */
// Testbench top for the fixed block pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 85;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [ADDR_W-1:0]    i_chunk_address;
    logic                 o_strobe;
    logic [ADDR_W-1:0]    o_granted_address;
    logic [STATUS_W-1:0]  o_status;
    logic [FREE_W-1:0]    o_free_chunks;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;

    int                fail_count;
    int                results_due;
    logic [ADDR_W-1:0] live_chunks[$];
    logic [ADDR_W-1:0] cur_base;
    int                n_alloc;
    int                n_free;
    int                n_writes;
    int                status_seen [0:7];
    bit                steady;

    fixed_block_pool_allocator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_chunk_address   (i_chunk_address),
        .o_strobe          (o_strobe),
        .o_granted_address (o_granted_address),
        .o_status          (o_status),
        .o_free_chunks     (o_free_chunks),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    fbpa_grant_monitor u_grant_monitor (
        .clk             (i_clk),
        .rst_n           (i_rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (i_opcode),
        .chunk_address   (i_chunk_address),
        .strobe          (o_strobe),
        .granted_address (o_granted_address),
        .status          (o_status),
        .free_chunks     (o_free_chunks),
        .cfg_we          (i_cfg_we),
        .cfg_index       (i_cfg_index),
        .cfg_data        (i_cfg_data),
        .fail_count      (fail_count),
        .results_due     (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_fixed_block_pool_allocator: done, errors");
        $finish;
    end

    // Granted addresses are kept so that later transactions can hand them back.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            status_seen[o_status]++;
            if (o_status == ST_OK && o_granted_address != '0) begin
                live_chunks.push_back(o_granted_address);
            end
        end
    end

    task automatic send_request(input t_opcode op, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_opcode = op;
        i_chunk_address = addr;
        do @(posedge i_clk); while (busy);
        if (op == OP_ALLOC) begin
            n_alloc++;
        end else begin
            n_free++;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (results_due != 0 || busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        n_writes++;
        if (idx == CFG_POOL_BASE) begin
            cur_base = data;
        end
        if (idx == CFG_POOL_SLOTS_USED) begin
            live_chunks.delete();
        end
    endtask

    task automatic configure_phase(input int p);
        logic [ADDR_W-1:0] obj;
        logic [ADDR_W-1:0] cnt;
        logic [ADDR_W-1:0] base;
        case (p)
            0: begin obj = 1;    cnt = 8;   base = 32'h0000_1000; end
            1: begin obj = 8191; cnt = 256; base = 32'hFFFF_0000; end
            2: begin obj = 4096; cnt = 1;   base = 32'hFFFF_FFFF; end
            3: begin obj = 0;    cnt = 0;   base = 32'h0000_0000; end
            4: begin obj = 17;   cnt = 511; base = 32'h8000_0000; end
            5: begin obj = 4097; cnt = 3;   base = 32'h0000_0010; end
            default: begin
                obj = $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom_range(0, 8191);
                if ($urandom_range(0, 3) == 0) begin
                    obj = obj | ($urandom() & 32'hFFFF_E000);
                end
                case ($urandom_range(0, 3))
                    0:       cnt = $urandom_range(0, 4);
                    1:       cnt = $urandom_range(1, 40);
                    default: cnt = $urandom_range(0, 511);
                endcase
                base = $urandom();
                if ($urandom_range(0, 1)) begin
                    base = base & 32'hFFFF_FFF0;
                end
            end
        endcase
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_OBJECT_BYTES, obj);
        write_reg(CFG_SPARE, $urandom());
        write_reg(CFG_POOL_SLOTS_USED, cnt);
    endtask

    task automatic random_item();
        int                pick;
        int                k;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 80 && live_chunks.size() == 0)) begin
            send_request(OP_ALLOC, $urandom());
        end else if (pick < 80) begin
            k = $urandom_range(0, live_chunks.size() - 1);
            addr = live_chunks[k];
            // A few chunks stay on the list so that they get freed twice.
            if ($urandom_range(0, 9) != 0) begin
                live_chunks.delete(k);
            end
            send_request(OP_FREE, addr);
        end else if (pick < 88 && live_chunks.size() != 0) begin
            k = $urandom_range(0, live_chunks.size() - 1);
            send_request(OP_FREE, live_chunks[k] + $urandom_range(1, ALIGNMENT - 1));
        end else if (pick < 92) begin
            send_request(OP_FREE, '0);
        end else if (pick < 96) begin
            send_request(OP_FREE, cur_base - $urandom_range(1, 64));
        end else begin
            send_request(OP_FREE, $urandom());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = 1'b0;
        i_chunk_address = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cur_base = ADDR_W'(RESET_BASE);
        steady = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset pool: 64 byte chunks, every slot free.
        send_request(OP_FREE, '0);
        send_request(OP_FREE, ADDR_W'(RESET_BASE));
        send_request(OP_FREE, ADDR_W'(RESET_BASE - 1));
        send_request(OP_FREE, ADDR_W'(RESET_BASE + RESET_OBJ * RESET_COUNT));
        send_request(OP_FREE, ADDR_W'(RESET_BASE + RESET_OBJ * (RESET_COUNT - 1)));
        send_request(OP_FREE, ADDR_W'(RESET_BASE + 4));
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, ADDR_W'(RESET_BASE + RESET_OBJ * (RESET_COUNT - 1)));
        send_request(OP_FREE, ADDR_W'(RESET_BASE + RESET_OBJ * (RESET_COUNT - 1)));
        send_request(OP_FREE, ADDR_W'(RESET_BASE + RESET_OBJ * (RESET_COUNT - 1)));
        send_request(OP_ALLOC, $urandom());

        write_reg(CFG_POOL_SLOTS_USED, 1);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, ADDR_W'(RESET_BASE));
        send_request(OP_FREE, ADDR_W'(RESET_BASE));

        write_reg(CFG_POOL_SLOTS_USED, 0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, ADDR_W'(RESET_BASE));

        for (int p = 0; p < PHASES; p++) begin
            configure_phase(p);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 20 == 0) begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                // Object size and base changes leave the free stack as it is.
                if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1)) begin
                    if ($urandom_range(0, 1)) begin
                        write_reg(CFG_OBJECT_BYTES, $urandom_range(0, 8191));
                    end else begin
                        write_reg(CFG_POOL_BASE, $urandom());
                    end
                end
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end
                random_item();
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d allocate and %0d free transactions across %0d register writes.",
                 n_alloc, n_free, n_writes);
        $display("Outcomes: ok %0d, exhausted %0d, null %0d, out of range %0d, misaligned %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_NULL],
                 status_seen[ST_RANGE], status_seen[ST_MISALIGNED], status_seen[ST_FULL]);
        if (fail_count == 0) begin
            $display("tb_fixed_block_pool_allocator: done, clean");
        end else begin
            $display("tb_fixed_block_pool_allocator: done, errors");
        end
        $finish;
    end

endmodule

/* fixed_block_pool_allocator.f */
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_stack.sv
hw/rtl/fixed_block_pool_allocator.sv
hw/rtl/fbpa_checker.sv
dv/fbpa_grant_monitor.sv
dv/tb_fixed_block_pool_allocator.sv
